### hdl/sih_pkg.sv
// ----------------------------------------------------------------------------
// sih_pkg
// Types, constants and mixing functions shared by the string ID hash block.
// ----------------------------------------------------------------------------
package sih_pkg;

  localparam int unsigned HashWidth  = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned TagWidth   = 16;
  localparam int unsigned ActWidth   = 2;

  // Shift amounts of the byte mix and of the final mix
  localparam int unsigned MixAddShift = 10;
  localparam int unsigned MixXorShift = 6;
  localparam int unsigned FinAddShift = 3;
  localparam int unsigned FinXorShift = 11;

  localparam logic [HashWidth-1:0] HashMaskHigh = 32'hFFFF_0000;

  // Reset value of the signed-byte control
  localparam logic SignedBytesReset = 1'b1;

  typedef enum logic [ActWidth-1:0] {
    ACT_APPEND        = 2'd0,
    ACT_APPEND_FINISH = 2'd1,
    ACT_FINISH        = 2'd2,
    ACT_IGNORE        = 2'd3
  } action_t;

  typedef logic [HashWidth-1:0] hash_t;
  typedef logic [ByteWidth-1:0] byte_t;
  typedef logic [TagWidth-1:0]  tag_t;

  // Add one byte (optionally sign-extended) and mix it into the running hash
  function automatic hash_t absorb_mix(hash_t h, byte_t b, logic sign_ext);
    hash_t ext;
    hash_t h0;
    hash_t h1;
    ext = {{(HashWidth-ByteWidth){sign_ext & b[ByteWidth-1]}}, b};
    h0  = h + ext;
    h1  = h0 + (h0 << MixAddShift);
    return h1 ^ (h1 >> MixXorShift);
  endfunction

  // Final avalanche, add the byte count, keep the high half, insert the tag
  function automatic hash_t finish_mix(hash_t h, hash_t count, tag_t tag);
    hash_t f0;
    hash_t f1;
    hash_t f2;
    f0 = h + (h << FinAddShift);
    f1 = f0 ^ (f0 >> FinXorShift);
    f2 = f1 + count;
    return (f2 & HashMaskHigh) | {{(HashWidth-TagWidth){1'b0}}, tag};
  endfunction

endpackage

### hdl/string_id_hash.sv
// ----------------------------------------------------------------------------
// string_id_hash
// One-at-a-time hash of a name streamed one byte per request, emitting a
// 32-bit identifier (upper hash half plus a caller tag) on finish.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, data_byte, id_low_tag.
//   Action append adds a byte, append-finish adds a byte and closes the name,
//   finish closes the name without a byte; the reserved code is dropped.
//   Output channel (out_valid/out_ready) carries hash_id, one per finish.
//   cfg_we/cfg_wdata write the signed_bytes control; write it only while
//   the block is idle. It resets to 1 (bytes treated as signed).
// Timing:
//   Three register stages: input register (with the running hash and byte
//   count beside it), final mix stage, output register. A finishing request
//   passes through all three to out_valid. One request per cycle is sustained
//   while in_ready stays high; the loop is a single add/shift/xor step per cycle.
// Reset clears the running hash, the byte count and all valid flags.
// When the receiver stalls, the output holds and the final mix stage fills;
// in_ready drops only while a finishing request waits in the input register
// behind a full final mix stage. Append requests keep flowing until then.
// ----------------------------------------------------------------------------
module string_id_hash (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sih_pkg::ActWidth-1:0]    action,
  input  logic [sih_pkg::ByteWidth-1:0]   data_byte,
  input  logic [sih_pkg::TagWidth-1:0]    id_low_tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sih_pkg::HashWidth-1:0]   hash_id
);
  import sih_pkg::*;

  logic    signed_bytes;

  // Input register
  logic    in_q_valid;
  action_t in_q_action;
  byte_t   in_q_byte;
  tag_t    in_q_tag;

  // Running state
  hash_t   running_hash;
  hash_t   byte_count;

  // Final mix stage
  logic    fin_valid;
  hash_t   fin_hash;
  hash_t   fin_count;
  tag_t    fin_tag;

  logic    in_q_finish;
  logic    in_q_append;
  logic    in_q_move;
  logic    fin_move;
  logic    fin_free;
  logic    out_free;
  hash_t   hash_absorbed;
  hash_t   count_absorbed;
  hash_t   hash_id_next;

  // Decode the held request and mix in its byte
  always_comb begin
    in_q_append    = (in_q_action == ACT_APPEND) || (in_q_action == ACT_APPEND_FINISH);
    in_q_finish    = (in_q_action == ACT_APPEND_FINISH) || (in_q_action == ACT_FINISH);
    hash_absorbed  = in_q_append ? absorb_mix(running_hash, in_q_byte, signed_bytes)
                                 : running_hash;
    count_absorbed = in_q_append ? byte_count + hash_t'(1) : byte_count;
    hash_id_next   = finish_mix(fin_hash, fin_count, fin_tag);
  end

  // Stage handshakes, from the output back to the input
  assign out_free  = !out_valid || out_ready;
  assign fin_move  = fin_valid && out_free;
  assign fin_free  = !fin_valid || fin_move;
  assign in_q_move = in_q_valid && (!in_q_finish || fin_free);
  assign in_ready  = !in_q_valid || in_q_move;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_bytes <= SignedBytesReset;
    end else if (cfg_we) begin
      signed_bytes <= cfg_wdata;
    end
  end

  // Capture a request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_action <= action_t'(action);
      in_q_byte   <= data_byte;
      in_q_tag    <= id_low_tag;
    end
  end

  // Advance the running hash; clear it when the name is closed
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      byte_count   <= '0;
    end else if (in_q_move) begin
      if (in_q_finish) begin
        running_hash <= '0;
        byte_count   <= '0;
      end else begin
        running_hash <= hash_absorbed;
        byte_count   <= count_absorbed;
      end
    end
  end

  // Hand a closed name to the final mix stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_free) begin
      fin_valid <= in_q_move && in_q_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (in_q_move && in_q_finish) begin
      fin_hash  <= hash_absorbed;
      fin_count <= count_absorbed;
      fin_tag   <= in_q_tag;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      hash_id <= hash_id_next;
    end
  end

  // Closing a name leaves the running state cleared
  assert property (@(posedge clk) disable iff (rst)
    (in_q_move && in_q_finish) |=> (running_hash == '0 && byte_count == '0))
    else $error("running state not cleared after finish");

  // Reserved action leaves the running state untouched
  assert property (@(posedge clk) disable iff (rst)
    (in_q_move && in_q_action == ACT_IGNORE) |=> ($stable(running_hash) && $stable(byte_count)))
    else $error("reserved action changed running state");

  // A stalled final-mix request is neither lost nor altered
  assert property (@(posedge clk) disable iff (rst)
    (fin_valid && !fin_move) |=> (fin_valid && $stable(fin_hash) && $stable(fin_tag)))
    else $error("final mix stage dropped a stalled request");

  // A request that cannot reach the final stage is held in the input register
  assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !in_q_move) |=> (in_q_valid && $stable(in_q_action)))
    else $error("input register dropped a stalled request");

  // Nothing leaves the block right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: string ID hash testbench
// Streams names into the hash block one byte per request and checks every
// identifier it emits against a cycle-free predictor of the one-at-a-time
// hash. A short table of directed requests comes first. Random names follow
// over several idle and stall profiles and both byte sign modes, plus a long
// receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sih_pkg::*;

  localparam int PhaseItems  = 300;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 80;

  typedef struct {
    action_t act;
    byte_t   data;
    tag_t    tag;
    bit      typed;
    hash_t   typed_id;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  action_t   action = ACT_APPEND;
  byte_t     data_byte = '0;
  tag_t      id_low_tag = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hash_t     hash_id;

  // Predictor state and control mirror
  hash_t     name_hash = '0;
  hash_t     name_len = '0;
  bit        sign_bytes = 1'b1;

  hash_t     pending_ids[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        items_sent = 0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  hash_t     oldest_id;

  dir_row_t  dir_rows [22] = '{
    '{ACT_FINISH,        8'h00, 16'h0000, 1'b1, 32'h0000_0000},
    '{ACT_FINISH,        8'hAB, 16'hFFFF, 1'b1, 32'h0000_FFFF},
    '{ACT_IGNORE,        8'hFF, 16'h1234, 1'b0, 32'h0},
    '{ACT_FINISH,        8'h00, 16'h5A5A, 1'b1, 32'h0000_5A5A},
    '{ACT_APPEND_FINISH, 8'h00, 16'h0001, 1'b0, 32'h0},
    '{ACT_APPEND_FINISH, 8'hFF, 16'hFFFF, 1'b0, 32'h0},
    '{ACT_APPEND_FINISH, 8'h7F, 16'h0000, 1'b0, 32'h0},
    '{ACT_APPEND_FINISH, 8'h80, 16'h8000, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h61, 16'h0000, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h62, 16'h0000, 1'b0, 32'h0},
    '{ACT_IGNORE,        8'h00, 16'hFFFF, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h63, 16'h0000, 1'b0, 32'h0},
    '{ACT_FINISH,        8'h00, 16'h0C0C, 1'b0, 32'h0},
    '{ACT_APPEND,        8'hFF, 16'h0000, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h80, 16'h0000, 1'b0, 32'h0},
    '{ACT_APPEND_FINISH, 8'h01, 16'hA5A5, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h00, 16'h0000, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h00, 16'h0000, 1'b0, 32'h0},
    '{ACT_APPEND,        8'h00, 16'h0000, 1'b0, 32'h0},
    '{ACT_FINISH,        8'h00, 16'h3333, 1'b0, 32'h0},
    '{ACT_FINISH,        8'hFF, 16'h7FFF, 1'b1, 32'h0000_7FFF},
    '{ACT_IGNORE,        8'h55, 16'hAAAA, 1'b0, 32'h0}
  };

  string_id_hash u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .data_byte  (data_byte),
    .id_low_tag (id_low_tag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_id    (hash_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the name hash by one request; return 1 when it closes a name
  function automatic bit name_hash_step(action_t act, byte_t b, tag_t t, output hash_t id);
    hash_t v;
    hash_t h;
    id = '0;
    if (act == ACT_APPEND || act == ACT_APPEND_FINISH) begin
      v = {24'h0, b};
      if (sign_bytes && b[7]) v[31:8] = '1;
      h = name_hash + v;
      h = h + (h << MixAddShift);
      h = h ^ (h >> MixXorShift);
      name_hash = h;
      name_len = name_len + 1;
    end
    if (act == ACT_APPEND_FINISH || act == ACT_FINISH) begin
      h = name_hash + (name_hash << FinAddShift);
      h = h ^ (h >> FinXorShift);
      h = h + name_len;
      id = {h[31:16], t};
      name_hash = '0;
      name_len = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one request, hold it until accepted, then record its identifier
  task automatic offer(action_t act, byte_t b, tag_t t, bit typed, hash_t typed_id);
    hash_t id;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    data_byte  <= b;
    id_low_tag <= t;
    do @(posedge clk); while (!in_ready);
    if (name_hash_step(act, b, t, id)) pending_ids = {pending_ids, (typed ? typed_id : id)};
  endtask

  // Drop valid and wait until every identifier is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_sign_mode(bit mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    sign_bytes = mode;
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed names; some noise, stray finishes and cut-off names
  task automatic send_random_name();
    int  r;
    int  len;
    bit  with_byte;
    bit  cut;
    r = $urandom_range(99);
    if (r < 6) begin
      offer(ACT_IGNORE, byte_t'($urandom), tag_t'($urandom), 1'b0, '0);
      return;
    end
    if (r < 10) begin
      offer(ACT_FINISH, byte_t'($urandom), tag_t'($urandom), 1'b0, '0);
      items_sent++;
      return;
    end
    len = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(8, 0);
    with_byte = (len > 0) && ($urandom_range(1) == 1);
    cut = ($urandom_range(19) == 0);
    for (int i = 0; i < len - with_byte; i++) begin
      if ($urandom_range(24) == 0)
        offer(ACT_IGNORE, byte_t'($urandom), tag_t'($urandom), 1'b0, '0);
      offer(ACT_APPEND, byte_t'($urandom), tag_t'($urandom), 1'b0, '0);
      items_sent++;
    end
    if (cut) return;
    offer(with_byte ? ACT_APPEND_FINISH : ACT_FINISH, byte_t'($urandom),
          tag_t'($urandom), 1'b0, '0);
    items_sent++;
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit mode);
    set_sign_mode(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    items_sent = 0;
    while (items_sent < PhaseItems) send_random_name();
  endtask

  // Receiver: check each identifier against the oldest one predicted
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_ids.size() == 0) begin
        $error("hash_id: no identifier expected, got %h", hash_id);
        mismatch_count++;
      end else begin
        oldest_id = pending_ids.pop_front();
        if (hash_id !== oldest_id) begin
          $error("hash_id: expected %h, got %h", oldest_id, hash_id);
          mismatch_count++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("string_id_hash test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset sign mode
    foreach (dir_rows[i])
      offer(dir_rows[i].act, dir_rows[i].data, dir_rows[i].tag,
            dir_rows[i].typed, dir_rows[i].typed_id);

    // Pause until empty, then hold the receiver off while requests keep coming
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      offer(ACT_APPEND_FINISH, byte_t'($urandom), tag_t'($urandom), 1'b0, '0);

    run_phase(0, 0, 1'b0);
    run_phase(74, 0, 1'b1);
    run_phase(0, 74, 1'b0);
    run_phase(31, 31, 1'b1);

    drain();
    if (mismatch_count == 0) begin
      $display("string_id_hash test passed");
    end else begin
      $display("string_id_hash test failed");
    end
    $finish;
  end

endmodule
